// ----- rtl/lbh_pkg.sv -----
// shared types, constants and the log2 fraction table for the log binned histogram
package lbh_pkg;

  localparam int NUM_BINS     = 4096;
  localparam int BIN_W        = $clog2(NUM_BINS);
  localparam int TABLE_BITS   = 8;
  localparam int TABLE_SIZE   = 1 << TABLE_BITS;
  localparam int SAMPLE_W     = 32;
  localparam int POS_W        = $clog2(SAMPLE_W);
  localparam int LOG_FRAC_W   = 10;
  localparam int FRAC_W       = LOG_FRAC_W + 1;
  localparam int LOG_W        = 16;
  localparam int LOG_BIAS     = 16 << LOG_FRAC_W;
  localparam int LOW_W        = 15;
  localparam int SCALE_W      = 24;
  localparam int USE_W        = 13;
  localparam int DIFF_W       = LOG_W;
  localparam int PROD_W       = DIFF_W + SCALE_W;
  localparam int BIN_SHIFT    = 18;
  localparam int BIN_FULL_W   = PROD_W - BIN_SHIFT;
  localparam int COUNT_W      = 32;
  localparam int LOST_W       = 24;

  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_LOG_LOW     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_SCALE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BINS_IN_USE = 2'd2;

  localparam logic [LOW_W-1:0]   LOG_LOW_RST     = 15'h4000;
  localparam logic [SCALE_W-1:0] BIN_SCALE_RST   = 24'd256;
  localparam logic [USE_W-1:0]   BINS_IN_USE_RST = 13'd4096;

  localparam logic MODE_ADD  = 1'b0;
  localparam logic MODE_READ = 1'b1;

  localparam int Q_DEPTH  = 8;
  localparam int Q_PTR_W  = $clog2(Q_DEPTH);
  localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);
  localparam int OB_DEPTH = 4;
  localparam int OB_PTR_W = $clog2(OB_DEPTH);
  localparam int OB_CNT_W = $clog2(OB_DEPTH + 1);

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [LOST_W-1:0]  LOST_MAX  = '1;

  typedef struct packed {
    logic             read_mode;
    logic             last;
    logic             kept;
    logic [BIN_W-1:0] bin;
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } push_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } head_t;

  typedef struct packed {
    logic [COUNT_W-1:0] bin_count;
    logic [LOST_W-1:0]  lost_count;
    logic [BIN_W-1:0]   bin_chosen;
    logic               sample_kept;
  } res_t;

  typedef logic [FRAC_W-1:0] frac_table_t [TABLE_SIZE];

  // round(1024 * log2(1 + m / 2^TABLE_BITS)) by repeated squaring
  function automatic logic [FRAC_W-1:0] log_frac_calc(int unsigned m);
    longint unsigned x;
    int unsigned     bits;
    x    = ((longint'(1) << TABLE_BITS) + longint'(m)) << (31 - TABLE_BITS);
    bits = 0;
    for (int k = 0; k < 16; k++) begin
      x    = (x * x) >> 31;
      bits = bits << 1;
      if (x >= (longint'(1) << 32)) begin
        bits = bits | 1;
        x    = x >> 1;
      end
    end
    return FRAC_W'((bits + 32) >> 6);
  endfunction

  function automatic frac_table_t build_frac_table();
    frac_table_t t;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      t[i] = log_frac_calc(i);
    end
    return t;
  endfunction

  localparam frac_table_t FRAC_TABLE = build_frac_table();

endpackage

// ----- rtl/lbh_if.sv -----
// sample and result channel interfaces
interface lbh_sample_if;
  import lbh_pkg::*;
  logic                valid;
  logic                ready;
  logic                mode;
  logic [SAMPLE_W-1:0] sample;
  logic [BIN_W-1:0]    bin_index;
  logic                last;
  modport source(output valid, mode, sample, bin_index, last, input ready);
  modport sink(input valid, mode, sample, bin_index, last, output ready);
endinterface

interface lbh_result_if;
  import lbh_pkg::*;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] bin_count;
  logic [LOST_W-1:0]  lost_count;
  logic [BIN_W-1:0]   bin_chosen;
  logic               sample_kept;
  modport source(output valid, bin_count, lost_count, bin_chosen, sample_kept, input ready);
  modport sink(input valid, bin_count, lost_count, bin_chosen, sample_kept, output ready);
endinterface

// ----- rtl/lbh_ram.sv -----
// generic single write port ram with registered read
module lbh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/lbh_front.sv -----
// front: config registers, log2 and bin classification pipeline
module lbh_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [lbh_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lbh_pkg::CFG_DATA_W-1:0]   cfg_data,
  lbh_sample_if.sink                       samples,
  input  logic [lbh_pkg::Q_CNT_W-1:0]      q_count,
  input  logic                             clear_done,
  output lbh_pkg::push_t                   push
);
  import lbh_pkg::*;

  logic [LOW_W-1:0]   log_low;
  logic [SCALE_W-1:0] bin_scale;
  logic [USE_W-1:0]   bins_in_use;

  logic                s1_valid, s2_valid, s3_valid;
  logic                s1_mode, s2_mode, s3_mode;
  logic                s1_last, s2_last, s3_last;
  logic [BIN_W-1:0]    s1_index, s2_index, s3_index;
  logic                s1_zero, s2_drop, s3_drop;
  logic [SAMPLE_W-1:0] s1_sample;
  logic [POS_W-1:0]    s1_pos;
  logic [DIFF_W-1:0]   s2_diff;
  logic [PROD_W-1:0]   s3_prod;

  logic                          accept;
  logic [Q_CNT_W-1:0]            pending;
  logic [POS_W-1:0]              lead_pos;
  logic [SAMPLE_W+TABLE_BITS-1:0] shifted;
  logic [TABLE_BITS-1:0]         mant;
  logic [LOG_W-1:0]              log_val;
  logic [LOG_W:0]                diff;
  logic [BIN_FULL_W-1:0]         bin_full;
  logic [USE_W-1:0]              limit;
  logic                          kept;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      log_low     <= LOG_LOW_RST;
      bin_scale   <= BIN_SCALE_RST;
      bins_in_use <= BINS_IN_USE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOG_LOW:     log_low     <= cfg_data[LOW_W-1:0];
        CFG_BIN_SCALE:   bin_scale   <= cfg_data[SCALE_W-1:0];
        CFG_BINS_IN_USE: bins_in_use <= cfg_data[USE_W-1:0];
        default: ;
      endcase
    end
  end

  // credit against queue space
  assign pending = q_count + Q_CNT_W'(s1_valid) + Q_CNT_W'(s2_valid) + Q_CNT_W'(s3_valid);
  assign samples.ready = clear_done && (pending < Q_CNT_W'(Q_DEPTH));
  assign accept = samples.valid && samples.ready;

  // leading one
  always_comb begin
    lead_pos = '0;
    for (int i = 0; i < SAMPLE_W; i++) begin
      if (samples.sample[i]) begin
        lead_pos = POS_W'(i);
      end
    end
  end

  assign shifted = {s1_sample, {TABLE_BITS{1'b0}}} >> s1_pos;
  assign mant    = shifted[TABLE_BITS-1:0];
  assign log_val = LOG_W'({s1_pos, {LOG_FRAC_W{1'b0}}}) - LOG_W'(LOG_BIAS)
                 + LOG_W'(FRAC_TABLE[mant]);
  assign diff    = {log_val[LOG_W-1], log_val} - (LOG_W+1)'(signed'(log_low));

  assign bin_full = s3_prod[PROD_W-1:BIN_SHIFT];
  assign limit    = (bins_in_use < USE_W'(NUM_BINS)) ? bins_in_use : USE_W'(NUM_BINS);
  assign kept     = !s3_drop && (bin_full < BIN_FULL_W'(limit));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_mode   <= samples.mode;
    s1_last   <= samples.last;
    s1_index  <= samples.bin_index;
    s1_zero   <= (samples.sample == '0);
    s1_sample <= samples.sample;
    s1_pos    <= lead_pos;

    s2_mode  <= s1_mode;
    s2_last  <= s1_last;
    s2_index <= s1_index;
    s2_drop  <= s1_zero || diff[LOG_W];
    s2_diff  <= diff[DIFF_W-1:0];

    s3_mode  <= s2_mode;
    s3_last  <= s2_last;
    s3_index <= s2_index;
    s3_drop  <= s2_drop;
    s3_prod  <= PROD_W'(s2_diff) * PROD_W'(bin_scale);
  end

  always_comb begin
    push.valid        = s3_valid;
    push.op.read_mode = s3_mode;
    push.op.last      = s3_last;
    push.op.kept      = (s3_mode == MODE_ADD) && kept;
    if (s3_mode == MODE_READ) begin
      push.op.bin = s3_index;
    end else if (kept) begin
      push.op.bin = bin_full[BIN_W-1:0];
    end else begin
      push.op.bin = '0;
    end
  end
endmodule

// ----- rtl/lbh_queue.sv -----
// short queue of classified operations between front and back
module lbh_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  lbh_pkg::push_t              push,
  input  logic                        pop,
  output lbh_pkg::head_t              head,
  output logic [lbh_pkg::Q_CNT_W-1:0] count
);
  import lbh_pkg::*;

  op_t                entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + Q_CNT_W'(push.valid) - Q_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      entries[wr_ptr] <= push.op;
    end
  end

  assign head.valid = (count != '0);
  assign head.op    = entries[rd_ptr];
endmodule

// ----- rtl/lbh_back.sv -----
// back: bin counter read-modify-write, lost counter, clearing pass and result buffer
module lbh_back (
  input  logic           clk,
  input  logic           rst,
  input  lbh_pkg::head_t head,
  output logic           pop,
  output logic           clear_done,
  lbh_result_if.source   results
);
  import lbh_pkg::*;

  logic                b1_valid;
  op_t                 b1_op;
  logic                fwd_valid;
  logic [BIN_W-1:0]    fwd_addr;
  logic [COUNT_W-1:0]  fwd_data;
  logic                clearing;
  logic [BIN_W-1:0]    clr_addr;
  logic [LOST_W-1:0]   lost;
  logic [LOST_W-1:0]   lost_next;

  logic                we;
  logic [BIN_W-1:0]    waddr;
  logic [COUNT_W-1:0]  wdata;
  logic [COUNT_W-1:0]  rdata;
  logic [COUNT_W-1:0]  cur;
  logic [COUNT_W-1:0]  inc;
  logic [LOST_W-1:0]   lost_new;
  logic                is_add;
  res_t                res;

  res_t                 obuf [OB_DEPTH];
  logic [OB_PTR_W-1:0]  ob_wr;
  logic [OB_PTR_W-1:0]  ob_rd;
  logic [OB_CNT_W-1:0]  ob_count;
  logic                 ob_pop;

  assign clear_done = !clearing;
  assign pop = head.valid && !clearing
            && ((ob_count + OB_CNT_W'(b1_valid)) < OB_CNT_W'(OB_DEPTH));

  lbh_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (NUM_BINS)
  ) u_counts (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (head.op.bin),
    .rdata (rdata)
  );

  // write from the previous cycle is not yet in the read data
  assign cur    = (fwd_valid && (fwd_addr == b1_op.bin)) ? fwd_data : rdata;
  assign inc    = (cur == COUNT_MAX) ? cur : cur + 1'b1;
  assign is_add = (b1_op.read_mode == MODE_ADD);

  assign we    = clearing || (b1_valid && is_add && b1_op.kept);
  assign waddr = clearing ? clr_addr : b1_op.bin;
  assign wdata = clearing ? '0 : inc;

  always_comb begin
    lost_new  = lost;
    lost_next = lost;
    res       = '0;
    if (is_add) begin
      if (!b1_op.kept && (lost != LOST_MAX)) begin
        lost_new = lost + 1'b1;
      end
      lost_next      = b1_op.last ? '0 : lost_new;
      res.lost_count = lost_new;
      if (b1_op.kept) begin
        res.bin_count   = inc;
        res.bin_chosen  = b1_op.bin;
        res.sample_kept = 1'b1;
      end
    end else begin
      res.bin_count  = cur;
      res.bin_chosen = b1_op.bin;
      res.lost_count = lost;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
      clearing  <= 1'b1;
      clr_addr  <= '0;
      lost      <= '0;
    end else begin
      b1_valid  <= pop;
      fwd_valid <= we;
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == BIN_W'(NUM_BINS - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (b1_valid) begin
        lost <= lost_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    b1_op    <= head.op;
    fwd_addr <= waddr;
    fwd_data <= wdata;
  end

  // result buffer
  assign ob_pop = results.valid && results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ob_wr    <= '0;
      ob_rd    <= '0;
      ob_count <= '0;
    end else begin
      if (b1_valid) begin
        ob_wr <= ob_wr + 1'b1;
      end
      if (ob_pop) begin
        ob_rd <= ob_rd + 1'b1;
      end
      ob_count <= ob_count + OB_CNT_W'(b1_valid) - OB_CNT_W'(ob_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (b1_valid) begin
      obuf[ob_wr] <= res;
    end
  end

  assign results.valid       = (ob_count != '0);
  assign results.bin_count   = obuf[ob_rd].bin_count;
  assign results.lost_count  = obuf[ob_rd].lost_count;
  assign results.bin_chosen  = obuf[ob_rd].bin_chosen;
  assign results.sample_kept = obuf[ob_rd].sample_kept;
endmodule

// ----- rtl/log_binned_histogram_core.sv -----
// top level of the logarithmic binned histogram
// Takes one transaction per clock cycle in steady state while results are not stalled
// and returns one result per transaction, in order, through three front stages
// (leading one, shift with log2 table and difference, scale multiply), the queue,
// the registered read on the bin counter memory, and the result buffer. The single
// read-modify-write port of the 4096 x 32 bin memory sets the rate; a write made
// in the cycle of a read is forwarded so repeated hits on one bin run back to back.
// After reset the bin memory is cleared one entry a cycle, all 4096 entries, during
// which no sample transaction is taken; config writes are taken at any time.
module log_binned_histogram_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [lbh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lbh_pkg::CFG_DATA_W-1:0] cfg_data,
  lbh_sample_if.sink                     samples,
  lbh_result_if.source                   results
);
  import lbh_pkg::*;

  push_t              push;
  head_t              head;
  logic               pop;
  logic               clear_done;
  logic [Q_CNT_W-1:0] q_count;

  lbh_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .samples    (samples),
    .q_count    (q_count),
    .clear_done (clear_done),
    .push       (push)
  );

  lbh_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .count (q_count)
  );

  lbh_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .pop        (pop),
    .clear_done (clear_done),
    .results    (results)
  );
endmodule

// ----- bench/testbench.sv -----
// self-checking testbench for log_binned_histogram_core: directed and random transactions
module testbench;
  import lbh_pkg::*;

  localparam int HOLD_CYCLES   = 120;
  localparam int SETTLE_CYCLES = 12;
  localparam int PHASE_ITEMS   = 80;
  localparam int STREAM_ITEMS  = 48;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  lbh_sample_if s_if ();
  lbh_result_if r_if ();

  log_binned_histogram_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (s_if),
    .results   (r_if)
  );

  // predicted histogram state and register copies
  logic [COUNT_W-1:0]       hist_counts [NUM_BINS];
  logic [LOST_W-1:0]        lost_tally;
  logic signed [LOW_W-1:0]  low_bound;
  logic [SCALE_W-1:0]       scale;
  logic [USE_W-1:0]         bins_used;

  res_t                     pending_results [$];
  logic [BIN_W-1:0]         recent_bins [$];
  logic [SAMPLE_W-1:0]      last_sample;

  int errors;
  int items_sent;
  int reads_sent;
  int results_seen;
  int kept_seen;
  int holds_done;
  int burst_left;
  bit no_gaps;
  bit hold_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // round(1024 * log2(1 + m / 2^TABLE_BITS)) by repeated squaring in Q1.31
  function automatic int log_fraction_q10(logic [TABLE_BITS-1:0] m);
    logic [63:0] acc;
    int unsigned bits;
    acc  = (64'(1 << TABLE_BITS) + 64'(m)) << (31 - TABLE_BITS);
    bits = 0;
    for (int k = 0; k < 16; k++) begin
      acc  = (acc * acc) >> 31;
      bits = bits << 1;
      if (acc >= 64'h1_0000_0000) begin
        bits = bits | 1;
        acc  = acc >> 1;
      end
    end
    return int'((bits + 32) >> 6);
  endfunction

  // signed Q6.10 log2 of a nonzero Q16.16 value
  function automatic int sample_log_q10(logic [SAMPLE_W-1:0] s);
    int                              lead;
    logic [SAMPLE_W+TABLE_BITS-1:0]  widened;
    logic [TABLE_BITS-1:0]           mant;
    lead = SAMPLE_W - 1;
    while (lead > 0 && !s[lead]) lead--;
    widened = {s, {TABLE_BITS{1'b0}}} >> lead;
    mant    = widened[TABLE_BITS-1:0];
    return (lead - 16) * 1024 + log_fraction_q10(mant);
  endfunction

  // applies one transaction to the predicted state and returns its result
  function automatic res_t bin_transaction(logic mode, logic [SAMPLE_W-1:0] sample,
                                           logic [BIN_W-1:0] index, logic last);
    res_t        r;
    int          diff;
    int          limit;
    logic [63:0] bin;
    bit          lost;
    r = '0;
    if (mode == MODE_READ) begin
      r.bin_count  = hist_counts[index];
      r.bin_chosen = index;
      r.lost_count = lost_tally;
      return r;
    end
    limit = (int'(bins_used) < NUM_BINS) ? int'(bins_used) : NUM_BINS;
    lost  = 1'b1;
    if (sample != '0) begin
      diff = sample_log_q10(sample) - int'(low_bound);
      if (diff >= 0) begin
        bin = (64'(diff) * 64'(scale)) >> BIN_SHIFT;
        if (bin < 64'(limit)) begin
          if (hist_counts[bin[BIN_W-1:0]] != COUNT_MAX)
            hist_counts[bin[BIN_W-1:0]] = hist_counts[bin[BIN_W-1:0]] + 1'b1;
          r.bin_count   = hist_counts[bin[BIN_W-1:0]];
          r.bin_chosen  = bin[BIN_W-1:0];
          r.sample_kept = 1'b1;
          lost          = 1'b0;
        end
      end
    end
    if (lost && lost_tally != LOST_MAX) lost_tally = lost_tally + 1'b1;
    r.lost_count = lost_tally;
    if (last) lost_tally = '0;
    return r;
  endfunction

  task automatic compare_field(string field, logic [COUNT_W-1:0] want, logic [COUNT_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      errors++;
    end
  endtask

  // result checker
  initial begin
    res_t want;
    forever begin
      @(posedge clk);
      if (!rst && r_if.valid === 1'b1 && r_if.ready === 1'b1) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result transaction with nothing pending, bin_chosen %0d",
                   $time, r_if.bin_chosen);
          errors++;
        end else begin
          want = pending_results.pop_front();
          compare_field("bin_count", want.bin_count, r_if.bin_count);
          compare_field("lost_count", COUNT_W'(want.lost_count), COUNT_W'(r_if.lost_count));
          compare_field("bin_chosen", COUNT_W'(want.bin_chosen), COUNT_W'(r_if.bin_chosen));
          compare_field("sample_kept", COUNT_W'(want.sample_kept), COUNT_W'(r_if.sample_kept));
          results_seen++;
          if (want.sample_kept) kept_seen++;
        end
      end
    end
  end

  // result side stall pattern, with a long hold-off on request
  initial begin
    int style;
    int phase_left;
    int hold_left;
    style      = 0;
    phase_left = 0;
    hold_left  = 0;
    r_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        r_if.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        holds_done++;
        r_if.ready <= 1'b0;
      end else begin
        if (phase_left == 0) begin
          style      = $urandom_range(0, 3);
          phase_left = $urandom_range(4, 40);
        end
        phase_left--;
        case (style)
          2: r_if.ready <= 1'($urandom_range(0, 1));
          3: r_if.ready <= ($urandom_range(0, 3) == 0);
          default: r_if.ready <= 1'b1;
        endcase
      end
    end
  end

  task automatic send_item(logic mode, logic [SAMPLE_W-1:0] sample,
                           logic [BIN_W-1:0] index, logic last);
    int   gap;
    res_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (no_gaps || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_if.valid     <= 1'b1;
    s_if.mode      <= mode;
    s_if.sample    <= sample;
    s_if.bin_index <= index;
    s_if.last      <= last;
    do @(posedge clk); while (s_if.ready !== 1'b1);
    r = bin_transaction(mode, sample, index, last);
    pending_results.push_back(r);
    items_sent++;
    if (mode == MODE_READ) reads_sent++;
    if (r.sample_kept) begin
      recent_bins.push_back(r.bin_chosen);
      if (recent_bins.size() > 16) void'(recent_bins.pop_front());
    end
  endtask

  task automatic drain();
    s_if.valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_LOG_LOW: low_bound = value[LOW_W-1:0];
      CFG_BIN_SCALE: scale = value[SCALE_W-1:0];
      CFG_BINS_IN_USE: bins_used = value[USE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(int low, int unsigned bin_scale, int unsigned bin_limit);
    logic [LOW_W-1:0] low_bits;
    low_bits = LOW_W'(low);
    write_reg(CFG_LOG_LOW, CFG_DATA_W'(low_bits));
    write_reg(CFG_BIN_SCALE, CFG_DATA_W'(bin_scale));
    write_reg(CFG_BINS_IN_USE, CFG_DATA_W'(bin_limit));
  endtask

  task automatic send_random_item();
    logic [BIN_W-1:0]    index;
    logic [SAMPLE_W-1:0] sample;
    int                  pick;
    if ($urandom_range(0, 6) == 0) begin
      if (recent_bins.size() != 0 && $urandom_range(0, 1) == 1)
        index = recent_bins[$urandom_range(0, recent_bins.size() - 1)];
      else
        index = BIN_W'($urandom);
      send_item(MODE_READ, $urandom, index, 1'($urandom_range(0, 1)));
    end else begin
      pick = $urandom_range(0, 39);
      if (pick == 0)
        sample = '0;
      else if (pick < 6)
        sample = last_sample;
      else
        sample = $urandom >> $urandom_range(0, 31);
      last_sample = sample;
      send_item(MODE_ADD, sample, BIN_W'($urandom), $urandom_range(0, 11) == 0);
    end
  endtask

  // reset domain: one bin per octave, 32 bins reachable
  task automatic test_default_domain();
    logic [SAMPLE_W-1:0] picks [9] = '{32'h0, 32'h1, 32'h3, 32'h5, 32'h0001_8000,
                                       32'hFFFF_FFFF, 32'h0001_0000, 32'h0001_0000,
                                       32'h0001_0000};
    for (int i = 0; i < 9; i++)
      send_item(MODE_ADD, picks[i], BIN_W'($urandom), i == 8);
  endtask

  task automatic test_read_back();
    send_item(MODE_ADD, '0, '0, 1'b0);
    send_item(MODE_READ, '1, BIN_W'(16), 1'b1);
    send_item(MODE_ADD, '0, '1, 1'b1);
    send_item(MODE_READ, '0, '0, 1'b0);
    send_item(MODE_READ, '0, BIN_W'(31), 1'b0);
    send_item(MODE_READ, '0, '1, 1'b1);
  endtask

  task automatic test_domain_extremes();
    drain();
    configure(16383, 256, 4096);
    send_item(MODE_ADD, 32'hFFFF_FFFF, '0, 1'b0);
    send_item(MODE_ADD, 32'h1, '0, 1'b1);
    drain();
    configure(-16384, 0, 4096);
    send_item(MODE_ADD, 32'h1, '0, 1'b0);
    send_item(MODE_ADD, 32'hFFFF_FFFF, '0, 1'b0);
    drain();
    configure(-16384, 16777215, 2);
    send_item(MODE_ADD, 32'h1, '0, 1'b0);
    send_item(MODE_ADD, 32'h2, '0, 1'b0);
    drain();
    configure(-16384, 256, 2);
    send_item(MODE_ADD, 32'h2, '0, 1'b0);
    send_item(MODE_ADD, 32'h4, '0, 1'b1);
    drain();
  endtask

  task automatic test_backpressure();
    configure(-16384, 16384, 4096);
    no_gaps  = 1'b1;
    hold_req = 1'b1;
    repeat (STREAM_ITEMS) send_random_item();
    no_gaps = 1'b0;
    drain();
  endtask

  task automatic test_random();
    configure(-16384, 32767, 4096);
    repeat (PHASE_ITEMS) send_random_item();
    drain();
    configure(-8192, 2048, 64);
    repeat (PHASE_ITEMS) send_random_item();
    drain();
    for (int p = 0; p < 3; p++) begin
      configure(int'($urandom_range(0, 16384)) - 16384, $urandom_range(256, 65535),
                $urandom_range(2, 4096));
      repeat (PHASE_ITEMS) send_random_item();
      drain();
    end
  endtask

  initial begin
    for (int i = 0; i < NUM_BINS; i++) hist_counts[i] = '0;
    lost_tally  = '0;
    low_bound   = LOG_LOW_RST;
    scale       = BIN_SCALE_RST;
    bins_used   = BINS_IN_USE_RST;
    last_sample = 32'h0001_0000;
    errors = 0;
    items_sent = 0;
    reads_sent = 0;
    results_seen = 0;
    kept_seen = 0;
    holds_done = 0;
    burst_left = 0;
    no_gaps = 1'b0;
    hold_req = 1'b0;
    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_LOG_LOW;
    cfg_data       <= '0;
    s_if.valid     <= 1'b0;
    s_if.mode      <= MODE_ADD;
    s_if.sample    <= '0;
    s_if.bin_index <= '0;
    s_if.last      <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_domain();
    test_read_back();
    test_domain_extremes();
    test_backpressure();
    test_random();
    drain();

    $display("sent %0d transactions (%0d reads), checked %0d results, %0d samples binned",
             items_sent, reads_sent, results_seen, kept_seen);
    $display("register settings covered domain and scale extremes, %0d long result hold-off(s)",
             holds_done);
    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
